@@ rtl/ptf_pkg.sv @@
// Shared types, codes, constants and the power-to-delay table for the triac firing block.
package ptf_pkg;

  localparam int POWER_W  = 12;
  localparam int TIMER_W  = 16;
  localparam int CMP_W    = 15;
  localparam int TSC_W    = 20;
  localparam int PULSE_W  = 8;
  localparam int SUM_W    = 23;
  localparam int FREQ_W   = 14;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 20;

  localparam int CROSSINGS_DEFAULT = 100;
  localparam logic [POWER_W-1:0] FULL_POWER = 12'd2048;

  localparam logic [TSC_W-1:0]   ALIVE_RESET = 20'd600000;
  localparam logic [PULSE_W-1:0] PULSE_RESET = 8'd8;
  localparam logic [TSC_W-1:0]   TSC_MAX     = {TSC_W{1'b1}};

  // period_sum / 400 = (period_sum >> 4) / 25, exact by reciprocal over the 19-bit range
  localparam int FREQ_PRE_SHIFT = 4;
  localparam int FREQ_Y_W       = SUM_W - FREQ_PRE_SHIFT;
  localparam int FREQ_RECIP_W   = 20;
  localparam logic [FREQ_RECIP_W-1:0] FREQ_RECIP = 20'd671089;
  localparam int FREQ_SHIFT     = 24;
  localparam int FREQ_PROD_W    = FREQ_Y_W + FREQ_RECIP_W;
  localparam int FREQ_Q_W       = FREQ_PROD_W - FREQ_SHIFT;
  localparam logic [FREQ_W-1:0] FREQ_MAX = {FREQ_W{1'b1}};

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_CROSS = 2'd1;
  localparam logic [1:0] OP_POWER = 2'd2;

  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_PHASE = 2'd1;
  localparam logic [1:0] MODE_FULL  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ALIVE_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GATE_PULSE    = 2'd1;

  typedef struct packed {
    logic             gate;
    logic             net_alive;
    logic [SUM_W-1:0] period_sum;
  } ptf_res_t;

  function automatic logic [CMP_W-1:0] power_to_delay(input logic [POWER_W-1:0] p);
    logic [CMP_W-1:0] base;
    logic [13:0]      slope;
    logic [21:0]      prod;
    case (p[10:8])
      3'd0: begin base = 15'd17300; slope = 14'd10791; end
      3'd1: begin base = 15'd14602; slope = 14'd9148;  end
      3'd2: begin base = 15'd12314; slope = 14'd6109;  end
      3'd3: begin base = 15'd10786; slope = 14'd2144;  end
      3'd4: begin base = 15'd10250; slope = 14'd2146;  end
      3'd5: begin base = 15'd9713;  slope = 14'd6111;  end
      3'd6: begin base = 15'd8185;  slope = 14'd9148;  end
      default: begin base = 15'd5897; slope = 14'd10787; end
    endcase
    prod = {8'b0000_0000, slope} * {14'b0, p[7:0]};
    power_to_delay = base - {3'b000, prod[21:10]};
  endfunction

endpackage

@@ rtl/ptf_core.sv @@
// Controller state update per input word and first result register stage.
module ptf_core #(
  parameter int CROSSINGS_PER_AVERAGE = ptf_pkg::CROSSINGS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_op,
  input  logic [ptf_pkg::POWER_W-1:0]   in_power,
  input  logic                          cfg_valid,
  input  logic [ptf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ptf_pkg::CFG_DAT_W-1:0] cfg_data,
  input  logic                          s2_ready,
  output logic                          s1_valid,
  output ptf_pkg::ptf_res_t             s1_res
);
  import ptf_pkg::*;

  localparam int CNT_W = $clog2(CROSSINGS_PER_AVERAGE);
  localparam logic [CNT_W:0] CNT_END = (CNT_W+1)'(CROSSINGS_PER_AVERAGE);

  logic [TSC_W-1:0]   alive_timeout_r;
  logic [PULSE_W-1:0] gate_pulse_r;
  logic [TIMER_W-1:0] timer_r, timer_nxt;
  logic [CMP_W-1:0]   cmp_r, cmp_nxt;
  logic [1:0]         mode_r, mode_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W:0]     cnt_inc;
  logic [SUM_W-1:0]   acc_r, acc_nxt, acc_sum;
  logic [SUM_W-1:0]   latched_r, latched_nxt;
  logic [TSC_W-1:0]   tsc_r, tsc_nxt;
  logic [PULSE_W-1:0] pulse_r, pulse_nxt;
  logic               valid_r;
  ptf_res_t           res_r, res_nxt;
  logic               accept;

  assign in_ready = !valid_r || s2_ready;
  assign accept   = in_valid && in_ready;
  assign s1_valid = valid_r;
  assign s1_res   = res_r;

  assign cnt_inc = {1'b0, cnt_r} + (CNT_W+1)'(1);
  assign acc_sum = acc_r + {{(SUM_W-TIMER_W){1'b0}}, timer_r};

  always_comb begin
    timer_nxt   = timer_r;
    cmp_nxt     = cmp_r;
    mode_nxt    = mode_r;
    cnt_nxt     = cnt_r;
    acc_nxt     = acc_r;
    latched_nxt = latched_r;
    tsc_nxt     = tsc_r;
    pulse_nxt   = pulse_r;
    case (in_op)
      OP_TICK: begin
        if (pulse_r != '0) pulse_nxt = pulse_r - PULSE_W'(1);
        timer_nxt = timer_r + TIMER_W'(1);
        if (mode_r == MODE_PHASE && timer_nxt == {1'b0, cmp_r}) pulse_nxt = gate_pulse_r;
        if (tsc_r != TSC_MAX) tsc_nxt = tsc_r + TSC_W'(1);
      end
      OP_CROSS: begin
        timer_nxt = '0;
        tsc_nxt   = '0;
        if (cnt_inc == CNT_END) begin
          cnt_nxt     = '0;
          latched_nxt = acc_sum;
          acc_nxt     = '0;
        end else begin
          cnt_nxt = cnt_inc[CNT_W-1:0];
          acc_nxt = acc_sum;
        end
      end
      OP_POWER: begin
        if (in_power == '0) begin
          mode_nxt  = MODE_OFF;
          pulse_nxt = '0;
        end else if (in_power >= FULL_POWER) begin
          mode_nxt  = MODE_FULL;
          pulse_nxt = '0;
        end else begin
          mode_nxt = MODE_PHASE;
          cmp_nxt  = power_to_delay(in_power);
        end
      end
      default: begin
      end
    endcase
    res_nxt.gate       = (mode_nxt == MODE_FULL) || (mode_nxt == MODE_PHASE && pulse_nxt != '0);
    res_nxt.net_alive  = tsc_nxt < alive_timeout_r;
    res_nxt.period_sum = latched_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alive_timeout_r <= ALIVE_RESET;
      gate_pulse_r    <= PULSE_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_ALIVE_TIMEOUT) alive_timeout_r <= cfg_data;
      else if (cfg_index == REG_GATE_PULSE) gate_pulse_r <= cfg_data[PULSE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_r   <= '0;
      cmp_r     <= '0;
      mode_r    <= MODE_OFF;
      cnt_r     <= '0;
      acc_r     <= '0;
      latched_r <= '0;
      tsc_r     <= ALIVE_RESET;
      pulse_r   <= '0;
      valid_r   <= 1'b0;
    end else begin
      if (accept) begin
        timer_r   <= timer_nxt;
        cmp_r     <= cmp_nxt;
        mode_r    <= mode_nxt;
        cnt_r     <= cnt_nxt;
        acc_r     <= acc_nxt;
        latched_r <= latched_nxt;
        tsc_r     <= tsc_nxt;
        pulse_r   <= pulse_nxt;
        valid_r   <= 1'b1;
      end else if (s2_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) res_r <= res_nxt;
  end

endmodule

@@ rtl/ptf_freq.sv @@
// Output register stage: frequency from the latched period sum by reciprocal multiply.
module ptf_freq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        s1_valid,
  input  ptf_pkg::ptf_res_t           s1_res,
  output logic                        s2_ready,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_gate,
  output logic                        out_net_alive,
  output logic [ptf_pkg::SUM_W-1:0]   out_period_sum,
  output logic [ptf_pkg::FREQ_W-1:0]  out_net_freq_centihz
);
  import ptf_pkg::*;

  logic [FREQ_Y_W-1:0]    y;
  logic [FREQ_PROD_W-1:0] prod;
  logic [FREQ_Q_W-1:0]    quot;
  logic [FREQ_W-1:0]      freq_nxt;
  logic                   valid_r;
  ptf_res_t               res_r;
  logic [FREQ_W-1:0]      freq_r;

  assign y        = s1_res.period_sum[SUM_W-1:FREQ_PRE_SHIFT];
  assign prod     = {{FREQ_RECIP_W{1'b0}}, y} * {{FREQ_Y_W{1'b0}}, FREQ_RECIP};
  assign quot     = prod[FREQ_PROD_W-1:FREQ_SHIFT];
  assign freq_nxt = (quot > FREQ_Q_W'(FREQ_MAX)) ? FREQ_MAX : quot[FREQ_W-1:0];

  assign s2_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s2_ready) begin
      valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      res_r  <= s1_res;
      freq_r <= freq_nxt;
    end
  end

  assign out_valid            = valid_r;
  assign out_gate             = res_r.gate;
  assign out_net_alive        = res_r.net_alive;
  assign out_period_sum       = res_r.period_sum;
  assign out_net_freq_centihz = freq_r;

endmodule

@@ rtl/phase_angle_triac_firing.sv @@
// Top level of the phase-angle triac firing controller.
// Input words are registered in the core stage, then in the frequency output stage.
// Throughput: one word per cycle unless out_ready stalls; state update closes in
// the first stage, the divide-by-400 reciprocal multiply sits in the second.
// Reset (synchronous, rst_n low): gate off, tick timer and sums zero, mains reads
// dead, registers back to 600000 and 8 ticks.
module phase_angle_triac_firing #(
  parameter int CROSSINGS_PER_AVERAGE = ptf_pkg::CROSSINGS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_op,
  input  logic [ptf_pkg::POWER_W-1:0]   in_power,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_gate,
  output logic                          out_net_alive,
  output logic [ptf_pkg::SUM_W-1:0]     out_period_sum,
  output logic [ptf_pkg::FREQ_W-1:0]    out_net_freq_centihz,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ptf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ptf_pkg::CFG_DAT_W-1:0] cfg_data
);
  import ptf_pkg::*;

  logic     s1_valid;
  logic     s2_ready;
  ptf_res_t s1_res;

  assign cfg_ready = 1'b1;

  ptf_core #(
    .CROSSINGS_PER_AVERAGE(CROSSINGS_PER_AVERAGE)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_op    (in_op),
    .in_power (in_power),
    .cfg_valid(cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s2_ready (s2_ready),
    .s1_valid (s1_valid),
    .s1_res   (s1_res)
  );

  ptf_freq u_freq (
    .clk                 (clk),
    .rst_n               (rst_n),
    .s1_valid            (s1_valid),
    .s1_res              (s1_res),
    .s2_ready            (s2_ready),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_gate            (out_gate),
    .out_net_alive       (out_net_alive),
    .out_period_sum      (out_period_sum),
    .out_net_freq_centihz(out_net_freq_centihz)
  );

  a_full_on: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op == OP_POWER && in_power >= FULL_POWER |=> s1_res.gate)
    else $error("full power did not drive gate high");

  a_off: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op == OP_POWER && in_power == '0 |=> !s1_res.gate)
    else $error("zero power left gate high");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid && out_valid && !out_ready)
    else $error("input stalled with room in the pipeline");

  a_freq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_net_freq_centihz != '0 |-> out_period_sum >= SUM_W'(400))
    else $error("frequency nonzero with period sum below one count");

endmodule
